// File: hdl/ptbsd_pkg.sv
// Shared types, constants and helpers of the point-to-box surface distance block.
`default_nettype none

package ptbsd_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIST_BITS = 32;
	localparam int REGION_BITS = 5;
	localparam int CFG_INDEX_BITS = 2;
	localparam int NUM_AXES = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] WIDTH_RESET = 32'd65536;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam logic [REGION_BITS-1:0] REGION_INSIDE = 5'd13;

	typedef enum logic [1:0] {
		BAND_BELOW  = 2'd0,
		BAND_INSIDE = 2'd1,
		BAND_ABOVE  = 2'd2
	} band_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDTH_X = 2'd0,
		REG_WIDTH_Y = 2'd1,
		REG_WIDTH_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	localparam int BAND_BITS = $bits(band_t);

	function automatic logic [REGION_BITS-1:0] region_of(band_t bx, band_t by, band_t bz);
		logic [REGION_BITS-1:0] r;
		r = REGION_BITS'(bx) * REGION_BITS'(9) + REGION_BITS'(by) * REGION_BITS'(3)
			+ REGION_BITS'(bz);
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/ptbsd_front.sv
// Front end: width registers, input register and per-axis band classification.
`default_nettype none

module ptbsd_front #(
	parameter int COORD_BITS = ptbsd_pkg::COORD_BITS,
	localparam int OD_BITS = COORD_BITS + 1,
	localparam int ENTRY_W = ptbsd_pkg::REGION_BITS
		+ ptbsd_pkg::NUM_AXES * (ptbsd_pkg::BAND_BITS + OD_BITS)
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [ptbsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [COORD_BITS-2:0]                    cfg_data,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic signed [COORD_BITS-1:0]             pos_x,
	input  wire logic signed [COORD_BITS-1:0]             pos_y,
	input  wire logic signed [COORD_BITS-1:0]             pos_z,
	output logic                                          push,
	output logic [ENTRY_W-1:0]                            push_data,
	input  wire ptbsd_pkg::qstat_t                        qstat
);

	localparam int SW = COORD_BITS + 2;
	localparam int NA = ptbsd_pkg::NUM_AXES;
	localparam int BB = ptbsd_pkg::BAND_BITS;

	logic [COORD_BITS-2:0]        width_q [NA];
	logic signed [COORD_BITS-1:0] pos [NA];
	logic signed [SW-1:0]         p2 [NA];
	logic signed [SW-1:0]         wi [NA];
	logic signed [SW-1:0]         s_up [NA];
	logic signed [SW-1:0]         s_dn [NA];
	logic signed [SW-1:0]         s_in [NA];
	ptbsd_pkg::band_t             band [NA];
	logic [OD_BITS-1:0]           axis_dist [NA];
	logic [ENTRY_W-1:0]           entry;
	logic                         fe_valid_s1;
	logic [ENTRY_W-1:0]           fe_entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NA; k++) begin
				width_q[k] <= (COORD_BITS-1)'(ptbsd_pkg::WIDTH_RESET);
			end
		end else if (cfg_we) begin
			case (ptbsd_pkg::cfg_reg_t'(cfg_index))
				ptbsd_pkg::REG_WIDTH_X: width_q[0] <= cfg_data;
				ptbsd_pkg::REG_WIDTH_Y: width_q[1] <= cfg_data;
				ptbsd_pkg::REG_WIDTH_Z: width_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	// Everything is held at twice the scale, so a half width needs no rounding.
	always_comb begin
		for (int k = 0; k < NA; k++) begin
			p2[k] = SW'(pos[k]) <<< 1;
			wi[k] = SW'(width_q[k]);
			s_up[k] = p2[k] - wi[k];
			s_dn[k] = p2[k] + wi[k];
			s_in[k] = wi[k] - p2[k];
			if (s_up[k] >= 0) begin
				band[k] = ptbsd_pkg::BAND_ABOVE;
				axis_dist[k] = OD_BITS'(s_up[k]);
			end else if (s_dn[k] <= 0) begin
				band[k] = ptbsd_pkg::BAND_BELOW;
				axis_dist[k] = OD_BITS'(-s_dn[k]);
			end else begin
				band[k] = ptbsd_pkg::BAND_INSIDE;
				axis_dist[k] = (s_in[k] < s_dn[k]) ? OD_BITS'(s_in[k]) : OD_BITS'(s_dn[k]);
			end
		end
		entry = '0;
		for (int k = 0; k < NA; k++) begin
			entry[k*OD_BITS +: OD_BITS] = axis_dist[k];
			entry[NA*OD_BITS + k*BB +: BB] = band[k];
		end
		entry[NA*(OD_BITS+BB) +: ptbsd_pkg::REGION_BITS] =
			ptbsd_pkg::region_of(band[0], band[1], band[2]);
	end

	assign in_stall = fe_valid_s1 & qstat.full;
	assign push = fe_valid_s1 & ~qstat.full;
	assign push_data = fe_entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			fe_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			fe_entry_s1 <= entry;
		end
	end

endmodule

`default_nettype wire

// File: hdl/ptbsd_queue.sv
// Short register queue that decouples the classifier from the distance pipeline.
`default_nettype none

module ptbsd_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = ptbsd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output ptbsd_pkg::qstat_t      stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	function automatic logic [AW-1:0] next_ptr(logic [AW-1:0] p);
		logic [AW-1:0] n;
		n = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	assign pop_data = mem_q[rd_ptr_q];
	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

// File: hdl/ptbsd_back.sv
// Back end: squares, sum, bit-per-stage square root, inside minimum and saturation.
`default_nettype none

module ptbsd_back #(
	parameter int COORD_BITS = ptbsd_pkg::COORD_BITS,
	localparam int OD_BITS = COORD_BITS + 1,
	localparam int ENTRY_W = ptbsd_pkg::REGION_BITS
		+ ptbsd_pkg::NUM_AXES * (ptbsd_pkg::BAND_BITS + OD_BITS)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ptbsd_pkg::qstat_t                    qstat,
	input  wire logic [ENTRY_W-1:0]                   pop_data,
	output logic                                      pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [ptbsd_pkg::DIST_BITS-1:0]           surface_distance,
	output logic [ptbsd_pkg::REGION_BITS-1:0]         region,
	output logic                                      inside_res
);

	localparam int NA = ptbsd_pkg::NUM_AXES;
	localparam int BB = ptbsd_pkg::BAND_BITS;
	localparam int RB = ptbsd_pkg::REGION_BITS;
	localparam int DB = ptbsd_pkg::DIST_BITS;
	localparam int LO = OD_BITS / 2;
	localparam int HI = OD_BITS - LO;
	localparam int SQ = 2 * OD_BITS;
	localparam int SUM = SQ + 2;
	localparam int ROOT_W = COORD_BITS + 2;
	localparam int MW = (ROOT_W > DB) ? ROOT_W : DB + 1;

	logic               adv;
	logic [OD_BITS-1:0] q_dist [NA];
	logic [OD_BITS-1:0] sq_in [NA];
	ptbsd_pkg::band_t   q_band [NA];
	logic [RB-1:0]      q_region;

	logic               valid_s1;
	logic [2*HI-1:0]    hh_s1 [NA];
	logic [OD_BITS-1:0] hl_s1 [NA];
	logic [2*LO-1:0]    ll_s1 [NA];
	logic [OD_BITS-1:0] min_s1;
	logic [OD_BITS-1:0] dz_s1;
	logic [RB-1:0]      region_s1;

	logic               valid_s2;
	logic [SQ-1:0]      sq_s2 [NA];
	logic [OD_BITS-1:0] min_s2;
	logic [RB-1:0]      region_s2;

	logic               rt_valid_s [ROOT_W+1];
	logic [SUM-1:0]     rt_rem_s [ROOT_W+1];
	logic [ROOT_W-1:0]  rt_root_s [1:ROOT_W];
	logic [RB-1:0]      rt_region_s [ROOT_W+1];
	logic [OD_BITS-2:0] rt_idist_s [ROOT_W+1];

	logic               out_valid_q;
	logic [DB-1:0]      dist_q;
	logic [RB-1:0]      region_q;
	logic               inside_q;
	logic               fin_inside;
	logic [MW-1:0]      cand;
	logic [DB-1:0]      fin_dist;

	assign adv = ~out_valid_q | ~out_stall;
	assign pop = adv & ~qstat.empty;

	always_comb begin
		for (int k = 0; k < NA; k++) begin
			q_dist[k] = pop_data[k*OD_BITS +: OD_BITS];
			q_band[k] = ptbsd_pkg::band_t'(pop_data[NA*OD_BITS + k*BB +: BB]);
			sq_in[k] = (q_band[k] == ptbsd_pkg::BAND_INSIDE) ? '0 : q_dist[k];
		end
		q_region = pop_data[NA*(OD_BITS+BB) +: RB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rt_valid_s[0] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ~qstat.empty;
			valid_s2 <= valid_s1;
			rt_valid_s[0] <= valid_s2;
			out_valid_q <= rt_valid_s[ROOT_W];
		end
	end

	// Each square is split into half-width partial products.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NA; k++) begin
				hh_s1[k] <= (2*HI)'(sq_in[k][OD_BITS-1:LO]) * (2*HI)'(sq_in[k][OD_BITS-1:LO]);
				hl_s1[k] <= OD_BITS'(sq_in[k][OD_BITS-1:LO]) * OD_BITS'(sq_in[k][LO-1:0]);
				ll_s1[k] <= (2*LO)'(sq_in[k][LO-1:0]) * (2*LO)'(sq_in[k][LO-1:0]);
			end
			min_s1 <= (q_dist[0] < q_dist[1]) ? q_dist[0] : q_dist[1];
			dz_s1 <= q_dist[2];
			region_s1 <= q_region;

			for (int k = 0; k < NA; k++) begin
				sq_s2[k] <= (SQ'(hh_s1[k]) << (2*LO)) + (SQ'(hl_s1[k]) << (LO+1))
					+ SQ'(ll_s1[k]);
			end
			min_s2 <= (min_s1 < dz_s1) ? min_s1 : dz_s1;
			region_s2 <= region_s1;

			rt_rem_s[0] <= SUM'(sq_s2[0]) + SUM'(sq_s2[1]) + SUM'(sq_s2[2]);
			rt_region_s[0] <= region_s2;
			rt_idist_s[0] <= min_s2[OD_BITS-1:1];
		end
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
		localparam int BIT = ROOT_W - k;
		logic [ROOT_W-1:0] root_in;
		logic [SUM-1:0]    trial;

		if (k == 1) begin : g_first
			assign root_in = '0;
		end else begin : g_next
			assign root_in = rt_root_s[k-1];
		end

		assign trial = (SUM'(root_in) << (BIT + 1)) | (SUM'(1) << (2 * BIT));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_valid_s[k] <= 1'b0;
			end else if (adv) begin
				rt_valid_s[k] <= rt_valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rt_rem_s[k-1] >= trial) begin
					rt_rem_s[k] <= rt_rem_s[k-1] - trial;
					rt_root_s[k] <= root_in | (ROOT_W'(1) << BIT);
				end else begin
					rt_rem_s[k] <= rt_rem_s[k-1];
					rt_root_s[k] <= root_in;
				end
				rt_region_s[k] <= rt_region_s[k-1];
				rt_idist_s[k] <= rt_idist_s[k-1];
			end
		end
	end

	always_comb begin
		fin_inside = (rt_region_s[ROOT_W] == ptbsd_pkg::REGION_INSIDE);
		cand = fin_inside ? MW'(rt_idist_s[ROOT_W]) : MW'(rt_root_s[ROOT_W][ROOT_W-1:1]);
		fin_dist = (cand > MW'(ptbsd_pkg::DIST_MAX)) ? ptbsd_pkg::DIST_MAX : cand[DB-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_q <= fin_dist;
			region_q <= rt_region_s[ROOT_W];
			inside_q <= fin_inside;
		end
	end

	assign out_valid = out_valid_q;
	assign surface_distance = dist_q;
	assign region = region_q;
	assign inside_res = inside_q;

endmodule

`default_nettype wire

// File: hdl/point_to_box_surface_distance.sv
// Top level of the point-to-box surface distance block.
// Throughput is one beat per cycle while the output is not stalled, carried by the square root
// pipeline that settles one bit a stage. A stalled output freezes the back pipeline; the four-entry
// queue keeps the input side moving until it fills, and then the input is stalled.
// Reset clears all valid and queue state and sets the three box widths to 1.0; nothing is swept.
`default_nettype none

module point_to_box_surface_distance #(
	parameter int COORD_BITS = ptbsd_pkg::COORD_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [ptbsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-2:0]                cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [COORD_BITS-1:0]         pos_x,
	input  wire logic signed [COORD_BITS-1:0]         pos_y,
	input  wire logic signed [COORD_BITS-1:0]         pos_z,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [ptbsd_pkg::DIST_BITS-1:0]           surface_distance,
	output logic [ptbsd_pkg::REGION_BITS-1:0]         region,
	output logic                                      inside_res
);

	localparam int OD_BITS = COORD_BITS + 1;
	localparam int ENTRY_W = ptbsd_pkg::REGION_BITS
		+ ptbsd_pkg::NUM_AXES * (ptbsd_pkg::BAND_BITS + OD_BITS);

	logic               q_push;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_push_data;
	logic [ENTRY_W-1:0] q_pop_data;
	ptbsd_pkg::qstat_t  q_stat;

	ptbsd_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.push(q_push),
		.push_data(q_push_data),
		.qstat(q_stat)
	);

	ptbsd_queue #(
		.DATA_W(ENTRY_W),
		.DEPTH(ptbsd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.pop(q_pop),
		.pop_data(q_pop_data),
		.stat(q_stat)
	);

	ptbsd_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(q_stat),
		.pop_data(q_pop_data),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.surface_distance(surface_distance),
		.region(region),
		.inside_res(inside_res)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled while the queue has room");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_inside_matches_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inside_res == (region == ptbsd_pkg::REGION_INSIDE)))
		else $error("inside flag disagrees with region code");

endmodule

`default_nettype wire

// File: bench/point_to_box_surface_distance_check.sv
// Checker that predicts every result beat of the point-to-box surface distance block and compares it.
`timescale 1ns / 100ps

module point_to_box_surface_distance_check (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [ptbsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [ptbsd_pkg::COORD_BITS-2:0]         cfg_data,
	input  wire logic                                     in_valid,
	input  wire logic                                     in_stall,
	input  wire logic signed [ptbsd_pkg::COORD_BITS-1:0]  pos_x,
	input  wire logic signed [ptbsd_pkg::COORD_BITS-1:0]  pos_y,
	input  wire logic signed [ptbsd_pkg::COORD_BITS-1:0]  pos_z,
	input  wire logic                                     out_valid,
	input  wire logic                                     out_stall,
	input  wire logic [ptbsd_pkg::DIST_BITS-1:0]          surface_distance,
	input  wire logic [ptbsd_pkg::REGION_BITS-1:0]        region,
	input  wire logic                                     inside_res,
	output int                                            fault_count,
	output int                                            pending,
	output int                                            results_seen,
	output int                                            regions_hit
);

	typedef struct packed {
		logic [ptbsd_pkg::DIST_BITS-1:0]   distance;
		logic [ptbsd_pkg::REGION_BITS-1:0] zone;
		logic                              interior;
	} surface_hit_t;

	surface_hit_t                     due_hits[$];
	logic [ptbsd_pkg::COORD_BITS-2:0] box_w [ptbsd_pkg::NUM_AXES];
	bit [26:0]                        zones_seen;

	// All lengths are kept at twice the coordinate scale so that half-LSB bounds stay exact.
	function automatic surface_hit_t surface_hit_of(
			input logic signed [ptbsd_pkg::COORD_BITS-1:0] px,
			input logic signed [ptbsd_pkg::COORD_BITS-1:0] py,
			input logic signed [ptbsd_pkg::COORD_BITS-1:0] pz);
		logic signed [ptbsd_pkg::COORD_BITS-1:0] p [ptbsd_pkg::NUM_AXES];
		ptbsd_pkg::band_t band [ptbsd_pkg::NUM_AXES];
		longint       twice, w, gap_in, nearest_in;
		logic [35:0]  gap_out, root;
		logic [71:0]  sq_sum, trial;
		logic [63:0]  span;
		int           zone;
		surface_hit_t hit;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		nearest_in = 64'sh7FFF_FFFF_FFFF_FFFF;
		sq_sum = '0;
		for (int a = 0; a < ptbsd_pkg::NUM_AXES; a++) begin
			twice = 2 * longint'(p[a]);
			w = longint'({1'b0, box_w[a]});
			gap_out = '0;
			if (twice >= w) begin
				band[a] = ptbsd_pkg::BAND_ABOVE;
				gap_out = 36'(twice - w);
			end else if (twice <= -w) begin
				band[a] = ptbsd_pkg::BAND_BELOW;
				gap_out = 36'(-w - twice);
			end else begin
				band[a] = ptbsd_pkg::BAND_INSIDE;
				gap_in = (w - twice < w + twice) ? w - twice : w + twice;
				if (gap_in < nearest_in)
					nearest_in = gap_in;
			end
			sq_sum += 72'(gap_out) * 72'(gap_out);
		end
		root = '0;
		for (int b = 35; b >= 0; b--) begin
			trial = 72'(root | (36'd1 << b));
			if (trial * trial <= sq_sum)
				root[b] = 1'b1;
		end
		zone = int'(band[0]) * 9 + int'(band[1]) * 3 + int'(band[2]);
		hit.zone = (ptbsd_pkg::REGION_BITS)'(zone);
		hit.interior = (hit.zone == ptbsd_pkg::REGION_INSIDE);
		if (hit.interior)
			span = 64'(nearest_in) >> 1;
		else
			span = 64'(root) >> 1;
		hit.distance = (span > 64'(ptbsd_pkg::DIST_MAX)) ? ptbsd_pkg::DIST_MAX
			: span[ptbsd_pkg::DIST_BITS-1:0];
		return hit;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		fault_count++;
		$display("%0t ns  mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		surface_hit_t want;
		if (!arst_n) begin
			due_hits.delete();
			box_w <= '{default: ptbsd_pkg::WIDTH_RESET[ptbsd_pkg::COORD_BITS-2:0]};
			pending <= 0;
			fault_count = 0;
			results_seen = 0;
			regions_hit = 0;
			zones_seen = '0;
		end else begin
			if (cfg_we) begin
				case (ptbsd_pkg::cfg_reg_t'(cfg_index))
					ptbsd_pkg::REG_WIDTH_X: box_w[0] <= cfg_data;
					ptbsd_pkg::REG_WIDTH_Y: box_w[1] <= cfg_data;
					ptbsd_pkg::REG_WIDTH_Z: box_w[2] <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_hits.insert(due_hits.size(), surface_hit_of(pos_x, pos_y, pos_z));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (region < 27)
					zones_seen[region] = 1'b1;
				regions_hit = $countones(zones_seen);
				if (due_hits.size() == 0) begin
					report("result beat with no point waiting", 64'(surface_distance), '0);
				end else begin
					want = due_hits.pop_front();
					if (surface_distance !== want.distance)
						report("surface_distance", 64'(surface_distance),
							64'(want.distance));
					if (region !== want.zone)
						report("region", 64'(region), 64'(want.zone));
					if (inside_res !== want.interior)
						report("inside_res", 64'(inside_res), 64'(want.interior));
				end
			end
			pending <= due_hits.size();
		end
	end

endmodule

// File: bench/point_to_box_surface_distance_test.sv
// Stimulus, clock, reset and verdict for the point-to-box surface distance block.
`timescale 1ns / 100ps

module point_to_box_surface_distance_test;

	localparam int PHASES = 8;
	localparam int POINTS_PER_PHASE = 235;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 50;

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    cfg_we = 1'b0;
	ptbsd_pkg::cfg_reg_t                     cfg_index = ptbsd_pkg::REG_WIDTH_X;
	logic [ptbsd_pkg::COORD_BITS-2:0]        cfg_data = '0;
	logic                                    in_valid = 1'b0;
	logic                                    in_stall;
	logic signed [ptbsd_pkg::COORD_BITS-1:0] pos_x = '0;
	logic signed [ptbsd_pkg::COORD_BITS-1:0] pos_y = '0;
	logic signed [ptbsd_pkg::COORD_BITS-1:0] pos_z = '0;
	logic                                    out_valid;
	logic                                    out_stall = 1'b0;
	logic [ptbsd_pkg::DIST_BITS-1:0]         surface_distance;
	logic [ptbsd_pkg::REGION_BITS-1:0]       region;
	logic                                    inside_res;

	int fault_count, pending, results_seen, regions_hit;
	int points_sent = 0;
	int quiet_cycles = 0;
	int hold_ask = 0;
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	logic [ptbsd_pkg::COORD_BITS-2:0] stim_w [ptbsd_pkg::NUM_AXES] =
		'{default: ptbsd_pkg::WIDTH_RESET[ptbsd_pkg::COORD_BITS-2:0]};

	point_to_box_surface_distance u_top (.*);

	point_to_box_surface_distance_check u_check (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: short random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				stall_left = hold_ask;
				hold_ask = 0;
			end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout after %0d cycles without a beat", WATCHDOG_LIMIT);
		$display("point_to_box_surface_distance_test: errors");
		$finish;
	end

	task automatic send_point(input logic [ptbsd_pkg::COORD_BITS-1:0] x,
			input logic [ptbsd_pkg::COORD_BITS-1:0] y,
			input logic [ptbsd_pkg::COORD_BITS-1:0] z);
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (in_stall);
		points_sent++;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_box(input logic [ptbsd_pkg::COORD_BITS-2:0] wx,
			input logic [ptbsd_pkg::COORD_BITS-2:0] wy,
			input logic [ptbsd_pkg::COORD_BITS-2:0] wz);
		cfg_we <= 1'b1;
		cfg_index <= ptbsd_pkg::REG_WIDTH_X;
		cfg_data <= wx;
		@(posedge clk);
		cfg_index <= ptbsd_pkg::REG_WIDTH_Y;
		cfg_data <= wy;
		@(posedge clk);
		cfg_index <= ptbsd_pkg::REG_WIDTH_Z;
		cfg_data <= wz;
		@(posedge clk);
		cfg_we <= 1'b0;
		stim_w[0] = wx;
		stim_w[1] = wy;
		stim_w[2] = wz;
	endtask

	function automatic logic [ptbsd_pkg::COORD_BITS-2:0] pick_width(input int ph);
		case (ph)
			0: return '0;
			1: return '1;
			2: return (ptbsd_pkg::COORD_BITS-1)'($urandom_range(0, 1 << 18));
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return (ptbsd_pkg::COORD_BITS-1)'($urandom_range(1, 1 << 20));
					default: return (ptbsd_pkg::COORD_BITS-1)'($urandom >> 1);
				endcase
			end
		endcase
	endfunction

	// Coordinates cluster around the faces and the centre, with some uniform noise.
	function automatic logic [ptbsd_pkg::COORD_BITS-1:0] pick_coord(
			input logic [ptbsd_pkg::COORD_BITS-2:0] w);
		longint half, v;
		half = longint'({1'b0, w}) >> 1;
		case ($urandom_range(0, 5))
			0: v = longint'($urandom);
			1: v = ($urandom_range(0, 1) ? half : -half) + longint'($urandom_range(0, 4)) - 2;
			2: v = longint'($urandom_range(0, w)) - half;
			3: v = longint'($urandom_range(0, 255)) - 128;
			4: begin
				case ($urandom_range(0, 3))
					0: v = 64'h7FFF_FFFF;
					1: v = 64'h8000_0000;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: v = (longint'($urandom_range(0, w)) - half) * 2
				+ longint'($urandom_range(0, 1));
		endcase
		return v[ptbsd_pkg::COORD_BITS-1:0];
	endfunction

	initial begin
		logic [ptbsd_pkg::COORD_BITS-1:0] c [ptbsd_pkg::NUM_AXES];
		logic [ptbsd_pkg::COORD_BITS-1:0] half;
		int                               b;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One point per region at the reset widths: faces hit exactly, full-scale corners,
		// and coordinates one LSB inside a face.
		for (int k = 0; k < 27; k++) begin
			for (int a = 0; a < ptbsd_pkg::NUM_AXES; a++) begin
				b = (a == 0) ? k / 9 : (a == 1) ? (k / 3) % 3 : k % 3;
				half = {1'b0, stim_w[a]} >> 1;
				case (ptbsd_pkg::band_t'(b))
					ptbsd_pkg::BAND_BELOW: c[a] = k[0] ? 32'h8000_0000 : -half;
					ptbsd_pkg::BAND_ABOVE: c[a] = k[0] ? 32'h7FFF_FFFF : half;
					default:               c[a] = k[1] ? half - 1 : '0;
				endcase
			end
			send_point(c[0], c[1], c[2]);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_box(pick_width(ph), pick_width(ph), pick_width(ph));
			tx_gaps = (ph != 3) && (ph % 3 != 1) && (ph != PHASES - 1);
			rx_gaps = (ph % 3 != 2) && (ph != PHASES - 1);
			if (ph == 3)
				hold_ask = LONG_HOLD;
			for (int n = 0; n < POINTS_PER_PHASE; n++)
				send_point(pick_coord(stim_w[0]), pick_coord(stim_w[1]), pick_coord(stim_w[2]));
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d points over %0d box settings, %0d results checked, %0d of 27 regions seen",
			points_sent, PHASES + 1, results_seen, regions_hit);
		$display("zero and full-scale widths covered; receiver held off %0d cycles once",
			LONG_HOLD);
		if (fault_count == 0 && pending == 0)
			$display("point_to_box_surface_distance_test: clean");
		else
			$display("point_to_box_surface_distance_test: errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/ptbsd_pkg.sv
hdl/ptbsd_front.sv
hdl/ptbsd_queue.sv
hdl/ptbsd_back.sv
hdl/point_to_box_surface_distance.sv
bench/point_to_box_surface_distance_check.sv
bench/point_to_box_surface_distance_test.sv
